### hdl/qrs_pkg.sv
// ---------------------------------------------------------------------------
// qrs_pkg: shared types and step functions for the quadratic root solver
// Payload structs, status codes, pipeline stage records and the per-stage
// square root and division steps.
// ---------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEG   = 2'd1;
    localparam logic [1:0] ST_AZERO = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam int SQ_STEPS  = 33;   // root bits of a 66-bit radicand
    localparam int DIV_STEPS = 49;   // quotient bits of the scaled numerator

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } qrs_in_t;

    typedef struct packed {
        logic signed [31:0] root_plus;
        logic signed [31:0] root_minus;
        logic [1:0]         status;
    } qrs_out_t;

    typedef struct packed {
        logic [65:0]        rad;
        logic [34:0]        rem;
        logic [32:0]        root;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic               azero;
        logic               neg;
    } sq_stage_t;

    // {remainder[31:0], numerator/quotient[48:0]}
    typedef struct packed {
        logic [80:0] w;
        logic        sgn;
    } dv_lane_t;

    typedef struct packed {
        dv_lane_t    p;
        dv_lane_t    m;
        logic [31:0] d;
        logic        azero;
        logic        neg;
    } dv_stage_t;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } clamp_t;

    // one bit of restoring square root
    function automatic sq_stage_t sq_step(sq_stage_t x);
        sq_stage_t   y;
        logic [36:0] rem2;
        logic [36:0] trial;
        logic [36:0] diff;
        y     = x;
        rem2  = {x.rem, x.rad[65:64]};
        trial = {2'b00, x.root, 2'b01};
        diff  = rem2 - trial;
        if (rem2 >= trial)
        begin
            y.rem  = diff[34:0];
            y.root = {x.root[31:0], 1'b1};
        end
        else
        begin
            y.rem  = rem2[34:0];
            y.root = {x.root[31:0], 1'b0};
        end
        y.rad = {x.rad[63:0], 2'b00};
        return y;
    endfunction

    // one bit of restoring division
    function automatic dv_lane_t dv_step(dv_lane_t x, logic [31:0] d);
        dv_lane_t    y;
        logic [32:0] top;
        logic [32:0] diff;
        y    = x;
        top  = x.w[80:48];
        diff = top - {1'b0, d};
        if (top >= {1'b0, d})
            y.w = {diff[31:0], x.w[47:0], 1'b1};
        else
            y.w = {top[31:0], x.w[47:0], 1'b0};
        return y;
    endfunction

    function automatic clamp_t clamp_q(logic [48:0] q, logic sgn);
        clamp_t r;
        r.sat = 1'b0;
        if (!sgn)
        begin
            if (q > 49'd2147483647)
            begin
                r.sat = 1'b1;
                r.val = 32'h7fff_ffff;
            end
            else
                r.val = q[31:0];
        end
        else
        begin
            if (q > 49'd2147483648)
            begin
                r.sat = 1'b1;
                r.val = 32'h8000_0000;
            end
            else
                r.val = (~q[31:0]) + 32'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/quadratic_root_solver.sv
// ---------------------------------------------------------------------------
// quadratic_root_solver: pipelined Q16.16 quadratic equation solver
// Discriminant b*b-4ac at full width, 33-stage square root, then two
// 49-stage dividers for (-b +/- s)*2^15 / a with saturation and status.
// ---------------------------------------------------------------------------
//  channel | signals                    | content
//  --------+----------------------------+------------------------------
//  eq      | eq_valid, eq_stall, eq     | coef_a, coef_b, coef_c
//  roots   | root_valid, root_stall,    | root_plus, root_minus, status
//          | roots                      |
//
//  One transfer per cycle in, one per cycle out while the pipeline advances;
//  results pass through the 33 square root stages and the 49 divider stages.
//  All stages advance together; when the output register holds a result
//  and root_stall is high, the whole pipeline holds and eq_stall is high.
//  Reset clears valid bits only.
// ---------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver
    import qrs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     eq_valid,
    output logic          eq_stall,
    input  wire qrs_in_t  eq,
    output logic          root_valid,
    input  wire logic     root_stall,
    output qrs_out_t      roots
);

    logic adv;

    logic               v0_reg;
    qrs_in_t            s0_reg;
    logic               v1_reg;
    logic signed [63:0] bb_reg;
    logic signed [63:0] ac_reg;
    logic signed [31:0] a1_reg;
    logic signed [31:0] b1_reg;

    logic [SQ_STEPS:0]  sqv_reg;
    sq_stage_t          sq_reg [0:SQ_STEPS];
    logic [DIV_STEPS:0] dvv_reg;
    dv_stage_t          dv_reg [0:DIV_STEPS];

    logic               out_v_reg;
    qrs_out_t           out_reg;

    sq_stage_t          sq0_next;
    dv_stage_t          dv0_next;
    qrs_out_t           out_next;

    assign adv        = !out_v_reg || !root_stall;
    assign eq_stall   = !adv;
    assign root_valid = out_v_reg;
    assign roots      = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            sqv_reg   <= '0;
            dvv_reg   <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg    <= eq_valid;
            v1_reg    <= v0_reg;
            sqv_reg   <= {sqv_reg[SQ_STEPS-1:0], v1_reg};
            dvv_reg   <= {dvv_reg[DIV_STEPS-1:0], sqv_reg[SQ_STEPS]};
            out_v_reg <= dvv_reg[DIV_STEPS];
        end
    end

    // input register and products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg <= eq;
            bb_reg <= s0_reg.coef_b * s0_reg.coef_b;
            ac_reg <= s0_reg.coef_a * s0_reg.coef_c;
            a1_reg <= s0_reg.coef_a;
            b1_reg <= s0_reg.coef_b;
        end
    end

    // discriminant, Q34.32, 66 bits signed
    always_comb
    begin
        logic signed [65:0] disc;
        disc           = {{2{bb_reg[63]}}, bb_reg} - {ac_reg, 2'b00};
        sq0_next.rad   = disc;
        sq0_next.rem   = '0;
        sq0_next.root  = '0;
        sq0_next.a     = a1_reg;
        sq0_next.b     = b1_reg;
        sq0_next.azero = (a1_reg == 32'sd0);
        sq0_next.neg   = disc[65];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            sq_reg[0] <= sq0_next;
    end

    genvar k;
    generate
        for (k = 0; k < SQ_STEPS; k++)
        begin : g_sq
            always_ff @(posedge clk)
            begin
                if (adv)
                    sq_reg[k+1] <= sq_step(sq_reg[k]);
            end
        end
    endgenerate

    // numerators -b +/- s, scaled by 2^15, as magnitudes, with quotient signs and |a|
    always_comb
    begin
        logic signed [34:0] nb;
        logic signed [34:0] s;
        logic signed [34:0] np;
        logic signed [34:0] nm;
        logic [33:0]        mp;
        logic [33:0]        mm;
        logic               an;
        nb = -{{3{sq_reg[SQ_STEPS].b[31]}}, sq_reg[SQ_STEPS].b};
        s  = {2'b00, sq_reg[SQ_STEPS].root};
        np = nb + s;
        nm = nb - s;
        mp = np[34] ? 34'(-np) : np[33:0];
        mm = nm[34] ? 34'(-nm) : nm[33:0];
        an = sq_reg[SQ_STEPS].a[31];
        dv0_next.p.w   = {32'd0, mp[33:0], 15'd0};
        dv0_next.p.sgn = np[34] ^ an;
        dv0_next.m.w   = {32'd0, mm[33:0], 15'd0};
        dv0_next.m.sgn = nm[34] ^ an;
        dv0_next.d     = an ? 32'(-sq_reg[SQ_STEPS].a) : sq_reg[SQ_STEPS].a;
        dv0_next.azero = sq_reg[SQ_STEPS].azero;
        dv0_next.neg   = sq_reg[SQ_STEPS].neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= dv0_next;
    end

    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_dv
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[k+1].p     <= dv_step(dv_reg[k].p, dv_reg[k].d);
                    dv_reg[k+1].m     <= dv_step(dv_reg[k].m, dv_reg[k].d);
                    dv_reg[k+1].d     <= dv_reg[k].d;
                    dv_reg[k+1].azero <= dv_reg[k].azero;
                    dv_reg[k+1].neg   <= dv_reg[k].neg;
                end
            end
        end
    endgenerate

    always_comb
    begin
        clamp_t cp;
        clamp_t cm;
        cp = clamp_q(dv_reg[DIV_STEPS].p.w[48:0], dv_reg[DIV_STEPS].p.sgn);
        cm = clamp_q(dv_reg[DIV_STEPS].m.w[48:0], dv_reg[DIV_STEPS].m.sgn);
        out_next.root_plus  = '0;
        out_next.root_minus = '0;
        if (dv_reg[DIV_STEPS].azero)
            out_next.status = ST_AZERO;
        else if (dv_reg[DIV_STEPS].neg)
            out_next.status = ST_NEG;
        else
        begin
            out_next.root_plus  = cp.val;
            out_next.root_minus = cm.val;
            out_next.status     = (cp.sat || cm.sat) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

endmodule

`default_nettype wire

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb: self-checking bench for quadratic_root_solver
// Streams Q16.16 coefficient sets through the solver under random idling on
// both channels and checks every root pair and status against a wide-integer
// predictor, in order.
// ---------------------------------------------------------------------------
module tb;
    import qrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1530;
    localparam int PAUSE_AT = 700;
    localparam int QUIET_LO = 300;
    localparam int QUIET_HI = 550;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     eq_valid = 1'b0;
    logic     eq_stall;
    qrs_in_t  eq = '0;
    logic     root_valid;
    logic     root_stall = 1'b0;
    qrs_out_t roots;

    qrs_in_t  pending_eqs[$];
    qrs_out_t expected_roots[$];
    int       sent_cnt = 0;
    int       error_cnt = 0;
    bit       stim_done = 1'b0;

    quadratic_root_solver dut (
        .clk(clk),
        .rst_n(rst_n),
        .eq_valid(eq_valid),
        .eq_stall(eq_stall),
        .eq(eq),
        .root_valid(root_valid),
        .root_stall(root_stall),
        .roots(roots)
    );

    always #2 clk = ~clk;

    // {sat, value}
    function automatic logic [32:0] clamp_root(logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return {1'b1, 32'h7fff_ffff};
        else if (v < -128'sd2147483648)
            return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic qrs_out_t solve_eq(qrs_in_t e);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] disc;
        logic signed [127:0] s;
        logic [127:0]        sq;
        logic [127:0]        trial;
        logic [32:0]         cp;
        logic [32:0]         cm;
        qrs_out_t            r;
        a = e.coef_a;
        b = e.coef_b;
        c = e.coef_c;
        r = '0;
        if (a == 0)
            r.status = ST_AZERO;
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc < 0)
                r.status = ST_NEG;
            else
            begin
                // floor square root, one bit at a time
                sq = '0;
                for (int i = 33; i >= 0; i--)
                begin
                    trial = sq | (128'd1 << i);
                    if (trial * trial <= disc)
                        sq = trial;
                end
                s  = sq;
                cp = clamp_root(((s - b) * 32768) / a);
                cm = clamp_root(((-b - s) * 32768) / a);
                r.root_plus  = cp[31:0];
                r.root_minus = cm[31:0];
                r.status     = (cp[32] || cm[32]) ? ST_SAT : ST_OK;
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            3: return $signed($urandom_range(0, 64)) - 32;
            4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic bit quiet();
        return sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI;
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        int sent_next;
        if (!rst_n)
            eq_valid <= 1'b0;
        else
        begin
            sent_next = sent_cnt;
            if (eq_valid && !eq_stall)
            begin
                expected_roots.push_back(solve_eq(eq));
                sent_next = sent_cnt + 1;
                sent_cnt <= sent_next;
            end
            if (!eq_valid || !eq_stall)
            begin
                // hold off after PAUSE_AT transfers until the pipeline drains
                if (pending_eqs.size() != 0
                    && !(sent_next == PAUSE_AT && expected_roots.size() != 0)
                    && (quiet() || $urandom_range(0, 99) >= 31))
                begin
                    eq       <= pending_eqs.pop_front();
                    eq_valid <= 1'b1;
                end
                else
                    eq_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        qrs_out_t want;
        if (!rst_n)
            root_stall <= 1'b0;
        else
        begin
            if (root_valid && !root_stall)
            begin
                if (expected_roots.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, roots);
                    error_cnt = error_cnt + 1;
                end
                else
                begin
                    want = expected_roots.pop_front();
                    if (roots.root_plus !== want.root_plus)
                    begin
                        $display("%0t: root_plus expected %h actual %h", $realtime,
                                 want.root_plus, roots.root_plus);
                        error_cnt = error_cnt + 1;
                    end
                    if (roots.root_minus !== want.root_minus)
                    begin
                        $display("%0t: root_minus expected %h actual %h", $realtime,
                                 want.root_minus, roots.root_minus);
                        error_cnt = error_cnt + 1;
                    end
                    if (roots.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, roots.status);
                        error_cnt = error_cnt + 1;
                    end
                end
            end
            root_stall <= !quiet() && $urandom_range(0, 99) < 31;
        end
    end

    initial
    begin
        qrs_in_t e;
        // zero a, negative discriminant, two real roots, double root,
        // saturation, and field extremes
        pending_eqs.push_back('{32'sh0, 32'sh0003_0000, 32'sh0001_0000});
        pending_eqs.push_back('{32'sh0, 32'sh8000_0000, 32'sh7fff_ffff});
        pending_eqs.push_back('{32'sh0001_0000, 32'sh0, 32'sh0001_0000});
        pending_eqs.push_back('{-32'sh0001_0000, 32'sh0, -32'sh0001_0000});
        pending_eqs.push_back('{32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000});
        pending_eqs.push_back('{32'sh0001_0000, -32'sh0002_0000, 32'sh0001_0000});
        pending_eqs.push_back('{32'sh0002_0000, 32'sh0001_0000, -32'sh0003_0000});
        pending_eqs.push_back('{32'sh1, 32'sh0001_0000, 32'sh0});
        pending_eqs.push_back('{-32'sh1, 32'sh0001_0000, 32'sh0});
        pending_eqs.push_back('{32'sh1, 32'sh0, -32'sh0001_0000});
        pending_eqs.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
        pending_eqs.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff});
        pending_eqs.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
        pending_eqs.push_back('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff});
        pending_eqs.push_back('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
        pending_eqs.push_back('{32'sh7fff_ffff, 32'sh0, 32'sh0});
        pending_eqs.push_back('{-32'sh1, -32'sh1, -32'sh1});
        pending_eqs.push_back('{32'sh1, 32'sh8000_0000, 32'sh8000_0000});
        pending_eqs.push_back('{32'sh0001_0000, 32'sh0, -32'sh0004_0000});
        pending_eqs.push_back('{32'sh0001_0000, 32'sh0, -32'sh0002_0000});
        for (int i = 0; i < N_RANDOM; i++)
        begin
            e.coef_a = ($urandom_range(0, 49) == 0) ? 32'sh0 : rand_coef();
            e.coef_b = rand_coef();
            e.coef_c = rand_coef();
            pending_eqs.push_back(e);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_eqs.size() == 0 && !eq_valid);
        wait (expected_roots.size() == 0);
        repeat (200) @(posedge clk);
        if (error_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### quadratic_root_solver.f
hdl/qrs_pkg.sv
hdl/quadratic_root_solver.sv
tb/tb.sv
